// ----- hw/rtl/pcs_pkg.sv -----
// ----------------------------------------------------------------------------
// PI clock servo package
// Shared widths, codes, state types and the command/status structs of the
// multiply-divide unit.
// ----------------------------------------------------------------------------
package pcs_pkg;

  localparam int OFFSET_BITS = 48;
  localparam int FRAC_BITS   = 16;
  localparam int TIME_BITS   = 63;
  localparam int FREQ_BITS   = 47;
  localparam int WORD_BITS   = 64;
  localparam int STEP_BITS   = $clog2(WORD_BITS);
  localparam int TERM_SHIFT  = 56 - FRAC_BITS;

  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 47;
  localparam int IN_DATA_W   = ((1 + OFFSET_BITS + TIME_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_W  = ((FREQ_BITS + 2 + 7) / 8) * 8;

  // Every intermediate value saturates at +-2^62.
  localparam logic signed [WORD_BITS-1:0] TERM_CAP = 64'sd1 <<< 62;
  // One second expressed in ppb, in the fixed-point frequency format.
  localparam logic signed [WORD_BITS-1:0] NS_PPB_Q = 64'sd1000000000 <<< FRAC_BITS;
  localparam logic [29:0] FREQ_CEIL = 30'd900000000;

  // Configuration register indexes.
  localparam logic [CFG_ADDR_W-1:0] REG_PROP_GAIN   = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_INT_GAIN    = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_WEIGHT      = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_MAX_FREQ    = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_STEP_THR    = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_FIRST_THR   = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] REG_EST_INT     = 3'd6;
  localparam logic [CFG_ADDR_W-1:0] REG_INIT_DRIFT  = 3'd7;

  // Servo phases.
  localparam logic [1:0] PHASE_SAMPLE   = 2'd0;
  localparam logic [1:0] PHASE_ESTIMATE = 2'd1;
  localparam logic [1:0] PHASE_TRACK    = 2'd2;

  // Reported servo states.
  localparam logic [1:0] ST_UNLOCKED = 2'd0;
  localparam logic [1:0] ST_JUMP     = 2'd1;
  localparam logic [1:0] ST_LOCKED   = 2'd2;

  typedef enum logic [0:0] {
    MDU_OP_MUL,
    MDU_OP_DIV
  } mdu_op_t;

  typedef enum logic [1:0] {
    MDU_IDLE,
    MDU_MUL,
    MDU_CHECK,
    MDU_DIV
  } mdu_mode_t;

  typedef struct packed {
    logic                 start;
    mdu_op_t              op;
    logic [WORD_BITS-1:0] operand_a;  // multiplicand or divisor
    logic [WORD_BITS-1:0] operand_b;  // multiplier
  } mdu_cmd_t;

  typedef struct packed {
    logic                   done;
    logic [2*WORD_BITS-1:0] result;   // product, or quotient in the low word
  } mdu_stat_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_MAG,
    S_FLAGS,
    S_DISPATCH,
    S_P1_TIME,
    S_P1_GAP,
    S_P1_DIFF,
    S_P1_MAG,
    S_P1_MUL,
    S_P1_MUL_WAIT,
    S_P1_DIV,
    S_P1_DIV_WAIT,
    S_P1_ACC,
    S_P1_CLAMP,
    S_P2_GAIN,
    S_P2_GAIN_WAIT,
    S_P2_OFFS,
    S_P2_OFFS_WAIT,
    S_P2_TERM,
    S_P2_SUM1,
    S_P2_SUM2,
    S_P2_CLAMP,
    S_FINISH
  } srv_state_t;

endpackage

// ----- hw/rtl/pcs_mdu.sv -----
// ----------------------------------------------------------------------------
// PI clock servo multiply-divide unit
// One 65-bit adder shared by a radix-2 shift-add multiplier (64 steps) and a
// restoring shift-subtract divider (one overflow check plus 64 steps).
// ----------------------------------------------------------------------------
module pcs_mdu
  import pcs_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  mdu_cmd_t  cmd,
  output mdu_stat_t stat
);

  mdu_mode_t            mode;
  mdu_mode_t            mode_next;
  logic [STEP_BITS-1:0] count;
  logic                 done;
  logic                 finish;
  logic [WORD_BITS-1:0] hi;
  logic [WORD_BITS-1:0] lo;
  logic [WORD_BITS-1:0] operand;

  logic [WORD_BITS:0]   add_x;
  logic [WORD_BITS:0]   add_y;
  logic                 add_cin;
  logic [WORD_BITS:0]   add_sum;
  logic                 last_step;

  assign last_step = (count == {STEP_BITS{1'b1}});

  // Adder operand selection per mode.
  always_comb begin
    add_x   = {1'b0, hi};
    add_y   = '0;
    add_cin = 1'b0;
    case (mode)
      MDU_MUL: begin
        add_y = lo[0] ? {1'b0, operand} : '0;
      end
      MDU_CHECK: begin
        add_y   = ~{1'b0, operand};
        add_cin = 1'b1;
      end
      MDU_DIV: begin
        add_x   = {hi, lo[WORD_BITS-1]};
        add_y   = ~{1'b0, operand};
        add_cin = 1'b1;
      end
      default: begin
      end
    endcase
    add_sum = add_x + add_y + {{WORD_BITS{1'b0}}, add_cin};
  end

  // A clear sign bit of the difference means the partial remainder covers the divisor.
  always_comb begin
    finish = 1'b0;
    case (mode)
      MDU_MUL:   finish = last_step;
      MDU_CHECK: finish = !add_sum[WORD_BITS];
      MDU_DIV:   finish = last_step;
      default:   finish = 1'b0;
    endcase
  end

  always_comb begin
    mode_next = mode;
    case (mode)
      MDU_IDLE: begin
        if (cmd.start) begin
          mode_next = (cmd.op == MDU_OP_MUL) ? MDU_MUL : MDU_CHECK;
        end
      end
      MDU_MUL: begin
        if (last_step) mode_next = MDU_IDLE;
      end
      MDU_CHECK: begin
        mode_next = add_sum[WORD_BITS] ? MDU_DIV : MDU_IDLE;
      end
      MDU_DIV: begin
        if (last_step) mode_next = MDU_IDLE;
      end
      default: mode_next = MDU_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MDU_IDLE;
      done <= 1'b0;
    end else begin
      mode <= mode_next;
      done <= finish;
    end
  end

  always_ff @(posedge clk) begin
    case (mode)
      MDU_IDLE: begin
        count <= '0;
        if (cmd.start) begin
          operand <= cmd.operand_a;
          if (cmd.op == MDU_OP_MUL) begin
            hi <= '0;
            lo <= cmd.operand_b;
          end
        end
      end
      MDU_MUL: begin
        {hi, lo} <= {add_sum, lo[WORD_BITS-1:1]};
        count    <= STEP_BITS'(count + 1'b1);
      end
      MDU_CHECK: begin
        // The quotient would not fit in one word: it saturates to all ones.
        if (!add_sum[WORD_BITS]) lo <= '1;
        count <= '0;
      end
      MDU_DIV: begin
        hi    <= add_sum[WORD_BITS] ? add_x[WORD_BITS-1:0] : add_sum[WORD_BITS-1:0];
        lo    <= {lo[WORD_BITS-2:0], ~add_sum[WORD_BITS]};
        count <= STEP_BITS'(count + 1'b1);
      end
      default: begin
      end
    endcase
  end

  assign stat.done   = done;
  assign stat.result = {hi, lo};

endmodule

// ----- hw/rtl/pi_clock_servo.sv -----
// ----------------------------------------------------------------------------
// PI clock servo
// Three-phase servo: sample, drift estimate, proportional-integral tracking,
// sequenced over a shared multiply-divide unit.
// ----------------------------------------------------------------------------
//  channel  | direction | contents (lowest bit first)
//  s_axis   | in        | restart, offset_ns[47:0], local_time_ns[62:0]
//  m_axis   | out       | freq_adjust[46:0], servo_state[1:0], zero pad
//  cfg      | in        | write enable, register index, write data
//
//  In the sample phase an item needs no multiply-divide operation; in the
//  estimate phase it needs up to one 64-step multiply and one 65-step divide,
//  and in the tracking phase four 64-step multiplies. A stalled output holds
//  the finished item until the output register is free.
//  Synchronous reset loads the register defaults and the servo start state.
//  s_axis_tready is high only while idle; a finished result waits in the
//  output register, and the next item is taken while it waits.
// ----------------------------------------------------------------------------
module pi_clock_servo
  import pcs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // restart, offset_ns, local_time_ns
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,   // freq_adjust, servo_state, pad
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  // Saturation helpers.
  function automatic logic signed [WORD_BITS-1:0] cap_term(input logic signed [WORD_BITS:0] s);
    logic signed [WORD_BITS-1:0] r;
    if (s > (WORD_BITS+1)'(TERM_CAP)) r = TERM_CAP;
    else if (s < -((WORD_BITS+1)'(TERM_CAP))) r = -TERM_CAP;
    else r = WORD_BITS'(s);
    return r;
  endfunction

  function automatic logic signed [WORD_BITS-1:0] sat_add(input logic signed [WORD_BITS-1:0] a,
                                                          input logic signed [WORD_BITS-1:0] b);
    logic signed [WORD_BITS:0] s;
    s = (WORD_BITS+1)'(a) + (WORD_BITS+1)'(b);
    return cap_term(s);
  endfunction

  function automatic logic signed [WORD_BITS-1:0] sat_sub(input logic signed [WORD_BITS-1:0] a,
                                                          input logic signed [WORD_BITS-1:0] b);
    logic signed [WORD_BITS:0] s;
    s = (WORD_BITS+1)'(a) - (WORD_BITS+1)'(b);
    return cap_term(s);
  endfunction

  function automatic logic signed [WORD_BITS-1:0] signed_cap(input logic [WORD_BITS-1:0] m,
                                                             input logic neg);
    logic signed [WORD_BITS-1:0] v;
    v = (m >= WORD_BITS'(TERM_CAP)) ? TERM_CAP : $signed(m);
    return neg ? -v : v;
  endfunction

  function automatic logic signed [WORD_BITS-1:0] clamp_freq(input logic signed [WORD_BITS-1:0] v,
                                                             input logic signed [WORD_BITS-1:0] l);
    logic signed [WORD_BITS-1:0] r;
    if (v < -l) r = -l;
    else if (v > l) r = l;
    else r = v;
    return r;
  endfunction

  // Product gain * weight * |offset| scaled down to the frequency format.
  function automatic logic signed [WORD_BITS-1:0] pi_term(input logic [2*WORD_BITS-1:0] p,
                                                          input logic neg);
    logic [WORD_BITS-1:0] m;
    if (p[2*WORD_BITS-1:TERM_SHIFT+WORD_BITS] != '0) m = '1;
    else m = p[TERM_SHIFT+WORD_BITS-1:TERM_SHIFT];
    return signed_cap(m, neg);
  endfunction

  // Configuration registers.
  logic [31:0]            prop_gain;
  logic [31:0]            int_gain;
  logic [31:0]            weight;
  logic [29:0]            max_freq;
  logic [FREQ_BITS-1:0]   step_thr;
  logic [FREQ_BITS-1:0]   first_thr;
  logic [35:0]            est_int;

  // Servo state.
  logic [1:0]                    phase;
  logic signed [OFFSET_BITS-1:0] first_offset;
  logic [TIME_BITS-1:0]          first_time;
  logic signed [WORD_BITS-1:0]   drift;
  logic signed [WORD_BITS-1:0]   last_freq;
  logic                          first_update;

  // Per-item working registers.
  logic signed [OFFSET_BITS-1:0] in_off;
  logic [TIME_BITS-1:0]          in_time;
  logic [OFFSET_BITS-1:0]        off_mag;
  logic signed [WORD_BITS-1:0]   lim;
  logic                          big_step;
  logic                          big_first;
  logic [TIME_BITS-1:0]          gap;
  logic signed [OFFSET_BITS:0]   d_off;
  logic signed [WORD_BITS-1:0]   a_val;
  logic [OFFSET_BITS:0]          d_mag;
  logic [WORD_BITS-2:0]          a_mag;
  logic                          q_neg;
  logic signed [WORD_BITS-1:0]   drift_sum;
  logic                          term_sel;
  logic signed [WORD_BITS-1:0]   term_p;
  logic signed [WORD_BITS-1:0]   term_i;
  logic signed [WORD_BITS-1:0]   pi_sum;
  logic signed [WORD_BITS-1:0]   res_ppb;
  logic [1:0]                    res_st;
  logic [OUT_DATA_W-1:0]         out_data;

  srv_state_t state;
  srv_state_t state_next;
  mdu_cmd_t   mdu_cmd;
  mdu_stat_t  mdu_stat;
  logic       out_load;
  logic       in_xfer;

  logic [29:0]                 mf_eff;
  logic                        time_back;
  logic                        gap_short;
  logic signed [WORD_BITS-1:0] drift_clamped;
  logic signed [WORD_BITS-1:0] pi_clamped;
  logic                        pi_in_range;

  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign mf_eff        = (max_freq > FREQ_CEIL) ? FREQ_CEIL : max_freq;
  assign time_back     = (first_time >= in_time);
  assign gap_short     = (gap < TIME_BITS'(est_int));
  assign drift_clamped = clamp_freq(drift_sum, lim);
  assign pi_clamped    = clamp_freq(pi_sum, lim);
  assign pi_in_range   = (pi_sum >= -lim) && (pi_sum <= lim);

  pcs_mdu u_mdu (
    .clk  (clk),
    .rst  (rst),
    .cmd  (mdu_cmd),
    .stat (mdu_stat)
  );

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_xfer) state_next = S_MAG;
      end
      S_MAG:   state_next = S_FLAGS;
      S_FLAGS: state_next = S_DISPATCH;
      S_DISPATCH: begin
        case (phase)
          PHASE_SAMPLE:   state_next = S_FINISH;
          PHASE_ESTIMATE: state_next = S_P1_TIME;
          PHASE_TRACK:    state_next = big_step ? S_FINISH : S_P2_GAIN;
          default:        state_next = S_FINISH;
        endcase
      end
      S_P1_TIME: state_next = time_back ? S_FINISH : S_P1_GAP;
      S_P1_GAP:  state_next = gap_short ? S_FINISH : S_P1_DIFF;
      S_P1_DIFF: state_next = S_P1_MAG;
      S_P1_MAG:  state_next = S_P1_MUL;
      S_P1_MUL:  state_next = S_P1_MUL_WAIT;
      S_P1_MUL_WAIT: begin
        if (mdu_stat.done) state_next = S_P1_DIV;
      end
      S_P1_DIV: state_next = S_P1_DIV_WAIT;
      S_P1_DIV_WAIT: begin
        if (mdu_stat.done) state_next = S_P1_ACC;
      end
      S_P1_ACC:   state_next = S_P1_CLAMP;
      S_P1_CLAMP: state_next = S_FINISH;
      S_P2_GAIN:  state_next = S_P2_GAIN_WAIT;
      S_P2_GAIN_WAIT: begin
        if (mdu_stat.done) state_next = S_P2_OFFS;
      end
      S_P2_OFFS: state_next = S_P2_OFFS_WAIT;
      S_P2_OFFS_WAIT: begin
        if (mdu_stat.done) state_next = S_P2_TERM;
      end
      S_P2_TERM:  state_next = term_sel ? S_P2_SUM1 : S_P2_GAIN;
      S_P2_SUM1:  state_next = S_P2_SUM2;
      S_P2_SUM2:  state_next = S_P2_CLAMP;
      S_P2_CLAMP: state_next = S_FINISH;
      S_FINISH: begin
        if (out_load) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // State outputs.
  always_comb begin
    s_axis_tready = 1'b0;
    mdu_cmd       = '0;
    out_load      = 1'b0;
    case (state)
      S_IDLE: s_axis_tready = 1'b1;
      S_P1_MUL: begin
        mdu_cmd.start     = 1'b1;
        mdu_cmd.op        = MDU_OP_MUL;
        mdu_cmd.operand_a = WORD_BITS'(a_mag);
        mdu_cmd.operand_b = WORD_BITS'(d_mag);
      end
      S_P1_DIV: begin
        mdu_cmd.start     = 1'b1;
        mdu_cmd.op        = MDU_OP_DIV;
        mdu_cmd.operand_a = WORD_BITS'(gap);
      end
      S_P2_GAIN: begin
        mdu_cmd.start     = 1'b1;
        mdu_cmd.op        = MDU_OP_MUL;
        mdu_cmd.operand_a = WORD_BITS'(term_sel ? int_gain : prop_gain);
        mdu_cmd.operand_b = WORD_BITS'(weight);
      end
      S_P2_OFFS: begin
        mdu_cmd.start     = 1'b1;
        mdu_cmd.op        = MDU_OP_MUL;
        mdu_cmd.operand_a = mdu_stat.result[WORD_BITS-1:0];
        mdu_cmd.operand_b = WORD_BITS'(off_mag);
      end
      S_FINISH: out_load = !m_axis_tvalid || m_axis_tready;
      default: begin
      end
    endcase
  end

  // Control state, configuration and servo state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      m_axis_tvalid <= 1'b0;
      prop_gain     <= 32'd187904819;
      int_gain      <= 32'd80530637;
      weight        <= 32'd268435456;
      max_freq      <= 30'd900000000;
      step_thr      <= '0;
      first_thr     <= FREQ_BITS'(20000);
      est_int       <= 36'd53280053;
      phase         <= PHASE_SAMPLE;
      first_offset  <= '0;
      first_time    <= '0;
      drift         <= '0;
      last_freq     <= '0;
      first_update  <= 1'b1;
    end else begin
      state <= state_next;

      if (out_load) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end

      if (cfg_we) begin
        case (cfg_addr)
          REG_PROP_GAIN:  prop_gain <= cfg_wdata[31:0];
          REG_INT_GAIN:   int_gain  <= cfg_wdata[31:0];
          REG_WEIGHT:     weight    <= cfg_wdata[31:0];
          REG_MAX_FREQ:   max_freq  <= cfg_wdata[29:0];
          REG_STEP_THR:   step_thr  <= cfg_wdata[FREQ_BITS-1:0];
          REG_FIRST_THR:  first_thr <= cfg_wdata[FREQ_BITS-1:0];
          REG_EST_INT:    est_int   <= cfg_wdata[35:0];
          REG_INIT_DRIFT: begin
            drift     <= WORD_BITS'($signed(cfg_wdata[FREQ_BITS-1:0]));
            last_freq <= WORD_BITS'($signed(cfg_wdata[FREQ_BITS-1:0]));
          end
          default: begin
          end
        endcase
      end

      case (state)
        S_IDLE: begin
          if (in_xfer && s_axis_tdata[0]) phase <= PHASE_SAMPLE;
        end
        S_DISPATCH: begin
          if (phase == PHASE_SAMPLE) begin
            first_offset <= in_off;
            first_time   <= in_time;
            phase        <= PHASE_ESTIMATE;
          end else if (phase == PHASE_TRACK && big_step) begin
            phase <= PHASE_SAMPLE;
          end
        end
        S_P1_TIME: begin
          if (time_back) phase <= PHASE_SAMPLE;
        end
        S_P1_CLAMP: begin
          drift <= drift_clamped;
          phase <= PHASE_TRACK;
        end
        S_P2_CLAMP: begin
          // The integral is frozen while the output saturates.
          if (pi_in_range) drift <= drift_sum;
        end
        S_FINISH: begin
          if (out_load) begin
            last_freq <= res_ppb;
            if (res_st != ST_UNLOCKED) first_update <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Working registers.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (in_xfer) begin
          in_off  <= $signed(s_axis_tdata[OFFSET_BITS:1]);
          in_time <= s_axis_tdata[OFFSET_BITS+TIME_BITS:OFFSET_BITS+1];
        end
      end
      S_MAG: begin
        off_mag  <= in_off[OFFSET_BITS-1] ? OFFSET_BITS'(-in_off) : OFFSET_BITS'(in_off);
        lim      <= $signed(WORD_BITS'(mf_eff) << FRAC_BITS);
        res_ppb  <= last_freq;
        res_st   <= ST_UNLOCKED;
        term_sel <= 1'b0;
      end
      S_FLAGS: begin
        big_step  <= (step_thr != '0) && (off_mag > OFFSET_BITS'(step_thr));
        big_first <= first_update && (first_thr != '0) && (off_mag > OFFSET_BITS'(first_thr));
      end
      S_P1_TIME: begin
        gap <= in_time - first_time;
      end
      S_P1_DIFF: begin
        d_off <= (OFFSET_BITS+1)'(in_off) - (OFFSET_BITS+1)'(first_offset);
        a_val <= sat_sub(NS_PPB_Q, drift);
      end
      S_P1_MAG: begin
        d_mag <= d_off[OFFSET_BITS] ? (OFFSET_BITS+1)'(-d_off) : (OFFSET_BITS+1)'(d_off);
        a_mag <= a_val[WORD_BITS-1] ? (WORD_BITS-1)'(-a_val) : (WORD_BITS-1)'(a_val);
        q_neg <= a_val[WORD_BITS-1] != d_off[OFFSET_BITS];
      end
      S_P1_ACC: begin
        drift_sum <= sat_add(drift, signed_cap(mdu_stat.result[WORD_BITS-1:0], q_neg));
      end
      S_P1_CLAMP: begin
        res_ppb <= drift_clamped;
        res_st  <= (big_first || big_step) ? ST_JUMP : ST_LOCKED;
      end
      S_P2_TERM: begin
        if (term_sel) begin
          term_i <= pi_term(mdu_stat.result, in_off[OFFSET_BITS-1]);
        end else begin
          term_p   <= pi_term(mdu_stat.result, in_off[OFFSET_BITS-1]);
          term_sel <= 1'b1;
        end
      end
      S_P2_SUM1: begin
        pi_sum    <= sat_add(term_p, drift);
        drift_sum <= sat_add(drift, term_i);
      end
      S_P2_SUM2: begin
        pi_sum <= sat_add(pi_sum, term_i);
      end
      S_P2_CLAMP: begin
        res_ppb <= pi_clamped;
        res_st  <= ST_LOCKED;
      end
      S_FINISH: begin
        if (out_load) begin
          out_data <= {{(OUT_DATA_W-FREQ_BITS-2){1'b0}}, res_st, res_ppb[FREQ_BITS-1:0]};
        end
      end
      default: begin
      end
    endcase
  end

  assign m_axis_tdata = out_data;

endmodule

// ----- tb/sv/pcs_servo_checker.sv -----
// ----------------------------------------------------------------------------
// PI clock servo checker
// Watches the sample, result and register-write channels. It keeps its own
// model of the servo, works out the result of every accepted sample, and
// compares each result transfer field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module pcs_servo_checker
  import pcs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  input  logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // restart, offset_ns, local_time_ns
  input  logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  input  logic [OUT_DATA_W-1:0] m_axis_tdata,   // freq_adjust, servo_state, pad
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int                    errors,
  output int                    pending
);

  localparam logic signed [63:0] SAT_LIMIT   = 64'sh4000_0000_0000_0000;
  // One billion ppb with 16 fraction bits.
  localparam logic signed [63:0] ONE_SEC_PPB = 64'sd65536000000000;
  localparam logic [29:0]        PPB_CEILING = 30'd900000000;

  typedef struct packed {
    logic [46:0] freq;
    logic [1:0]  state;
  } servo_out_t;

  servo_out_t predicted_adjust[$];

  logic [31:0]        kp, ki, weight;
  logic [29:0]        max_freq;
  logic [46:0]        step_thr, first_thr;
  logic [35:0]        est_interval;
  logic [1:0]         phase;
  logic signed [63:0] first_off;
  logic [62:0]        first_stamp;
  logic signed [63:0] drift, last_freq;
  logic               first_upd;

  function automatic logic signed [63:0] clip(input logic signed [65:0] x);
    if (x > SAT_LIMIT) return SAT_LIMIT;
    if (x < -SAT_LIMIT) return -SAT_LIMIT;
    return x[63:0];
  endfunction

  function automatic logic signed [63:0] add_sat(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    return clip($signed({{2{a[63]}}, a}) + $signed({{2{b[63]}}, b}));
  endfunction

  function automatic logic signed [63:0] sub_sat(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    return clip($signed({{2{a[63]}}, a}) - $signed({{2{b[63]}}, b}));
  endfunction

  function automatic logic [63:0] abs_val(input logic signed [63:0] x);
    return x[63] ? -x : x;
  endfunction

  function automatic logic signed [63:0] signed_limit(input logic [63:0] m,
                                                      input logic neg);
    logic signed [63:0] v;
    v = (m >= 64'h4000_0000_0000_0000) ? SAT_LIMIT : $signed(m);
    return neg ? -v : v;
  endfunction

  function automatic logic signed [63:0] limit_freq(input logic signed [63:0] v,
                                                    input logic signed [63:0] lim);
    if (v < -lim) return -lim;
    if (v > lim) return lim;
    return v;
  endfunction

  // gain * weight in Q8.56, times |offset|, brought down to 16 fraction bits.
  function automatic logic signed [63:0] pi_term(input logic [31:0] gain,
                                                 input logic signed [63:0] off);
    logic [63:0]  gw;
    logic [127:0] prod;
    gw   = {32'd0, gain} * {32'd0, weight};
    prod = {64'd0, gw} * {64'd0, abs_val(off)};
    if (prod[127:104] != '0) return signed_limit('1, off[63]);
    return signed_limit(prod[103:40], off[63]);
  endfunction

  task automatic servo_update(input logic [IN_DATA_W-1:0] item);
    logic               restart, big_jump, big_first;
    logic signed [63:0] off, lim, ppb, d_off, room, q, pt, it, sum;
    logic [62:0]        stamp, gap;
    logic [63:0]        off_mag, q_mag;
    logic [29:0]        mf;
    logic [127:0]       prod;
    logic [1:0]         st;
    restart  = item[0];
    off      = $signed({{16{item[48]}}, item[48:1]});
    stamp    = item[111:49];
    off_mag  = abs_val(off);
    mf       = (max_freq > PPB_CEILING) ? PPB_CEILING : max_freq;
    lim      = $signed({18'd0, mf, 16'd0});
    big_jump = (step_thr != '0) && (off_mag > {17'd0, step_thr});
    ppb      = last_freq;
    st       = ST_UNLOCKED;
    if (restart) phase = PHASE_SAMPLE;
    case (phase)
      PHASE_SAMPLE: begin
        first_off   = off;
        first_stamp = stamp;
        phase       = PHASE_ESTIMATE;
      end
      PHASE_ESTIMATE: begin
        if (first_stamp >= stamp) begin
          phase = PHASE_SAMPLE;
        end else begin
          gap = stamp - first_stamp;
          if (gap >= {27'd0, est_interval}) begin
            d_off = sub_sat(off, first_off);
            room  = sub_sat(ONE_SEC_PPB, drift);
            prod  = {64'd0, abs_val(room)} * {64'd0, abs_val(d_off)};
            // A quotient that does not fit in 64 bits saturates.
            if (prod[127:64] >= {1'b0, gap}) q_mag = '1;
            else q_mag = 64'(prod / {65'd0, gap});
            q = signed_limit(q_mag, room[63] ^ d_off[63]);
            big_first = first_upd && (first_thr != '0) && (off_mag > {17'd0, first_thr});
            drift = limit_freq(add_sat(drift, q), lim);
            st    = (big_first || big_jump) ? ST_JUMP : ST_LOCKED;
            ppb   = drift;
            phase = PHASE_TRACK;
          end
        end
      end
      PHASE_TRACK: begin
        if (big_jump) begin
          phase = PHASE_SAMPLE;
        end else begin
          pt  = pi_term(kp, off);
          it  = pi_term(ki, off);
          sum = add_sat(add_sat(pt, drift), it);
          // The integral is frozen while the output sits at the clamp.
          if (sum < -lim) begin
            ppb = -lim;
          end else if (sum > lim) begin
            ppb = lim;
          end else begin
            ppb   = sum;
            drift = add_sat(drift, it);
          end
          st = ST_LOCKED;
        end
      end
      default: ;
    endcase
    last_freq = ppb;
    if (st != ST_UNLOCKED) first_upd = 1'b0;
    predicted_adjust.push_back('{freq: ppb[46:0], state: st});
  endtask

  task automatic check_adjust(input logic [OUT_DATA_W-1:0] data);
    servo_out_t  want;
    logic [46:0] got_freq;
    logic [1:0]  got_state;
    got_freq  = data[46:0];
    got_state = data[48:47];
    if (predicted_adjust.size() == 0) begin
      $error("result transfer with no sample waiting: freq_adjust %0d, servo_state %0d",
             $signed(got_freq), got_state);
      errors++;
    end else begin
      want = predicted_adjust.pop_front();
      if (got_freq != want.freq) begin
        $error("freq_adjust: expected %0d, got %0d", $signed(want.freq), $signed(got_freq));
        errors++;
      end
      if (got_state != want.state) begin
        $error("servo_state: expected %0d, got %0d", want.state, got_state);
        errors++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      kp           = 32'd187904819;
      ki           = 32'd80530637;
      weight       = 32'd268435456;
      max_freq     = 30'd900000000;
      step_thr     = '0;
      first_thr    = 47'd20000;
      est_interval = 36'd53280053;
      phase        = PHASE_SAMPLE;
      first_off    = '0;
      first_stamp  = '0;
      drift        = '0;
      last_freq    = '0;
      first_upd    = 1'b1;
      predicted_adjust.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          REG_PROP_GAIN:  kp           = cfg_wdata[31:0];
          REG_INT_GAIN:   ki           = cfg_wdata[31:0];
          REG_WEIGHT:     weight       = cfg_wdata[31:0];
          REG_MAX_FREQ:   max_freq     = cfg_wdata[29:0];
          REG_STEP_THR:   step_thr     = cfg_wdata[46:0];
          REG_FIRST_THR:  first_thr    = cfg_wdata[46:0];
          REG_EST_INT:    est_interval = cfg_wdata[35:0];
          REG_INIT_DRIFT: begin
            drift     = $signed({{17{cfg_wdata[46]}}, cfg_wdata[46:0]});
            last_freq = drift;
          end
          default: ;
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) check_adjust(m_axis_tdata);
      if (s_axis_tvalid && s_axis_tready) servo_update(s_axis_tdata);
    end
    pending = predicted_adjust.size();
  end

endmodule

// ----- tb/sv/tb_pi_clock_servo.sv -----
// ----------------------------------------------------------------------------
// PI clock servo testbench
// Drives offset samples through the servo in directed and random sequences
// across several register settings, with random gaps on both channels and
// one long result hold-off. The checker beside the block predicts and
// compares; this module makes the stimulus and reports the verdict.
// ----------------------------------------------------------------------------
module tb_pi_clock_servo
  import pcs_pkg::*;
;

  localparam int STALL_LIMIT   = 12000;
  localparam int LONG_HOLD     = 1500;
  localparam int HOLD_AFTER    = 300;
  localparam int SEGMENTS      = 8;
  localparam int SEGMENT_ITEMS = 92;

  logic                  clk           = 1'b0;
  logic                  rst           = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  cfg_we        = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr      = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata     = '0;

  int          errors;
  int          pending;
  int          items_sent    = 0;
  int          segment_items = 0;
  int          stall_cycles  = 0;
  logic        sender_quiet  = 1'b0;
  logic [62:0] now_ns        = '0;
  logic [35:0] est_gap       = 36'd53280053;

  pi_clock_servo u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata)
  );

  pcs_servo_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata),
    .errors        (errors),
    .pending       (pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int unsigned pick_gap(input logic quiet);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(20, 300);
  endfunction

  function automatic logic [47:0] offset_near_zero(input int unsigned max_bits);
    logic [63:0] raw;
    logic [47:0] m;
    raw = {$urandom, $urandom};
    m   = raw[47:0] & ((48'd1 << $urandom_range(1, max_bits)) - 48'd1);
    return ($urandom_range(0, 1) != 0) ? -m : m;
  endfunction

  function automatic logic [47:0] random_offset();
    int unsigned pick;
    logic [63:0] raw;
    pick = $urandom_range(0, 9);
    raw  = {$urandom, $urandom};
    if (pick < 2) return raw[47:0];
    if (pick == 2) begin
      case ($urandom_range(0, 3))
        0: return 48'h7FFF_FFFF_FFFF;
        1: return 48'h8000_0000_0000;
        2: return 48'h0;
        default: return 48'hFFFF_FFFF_FFFF;
      endcase
    end
    return offset_near_zero(30);
  endfunction

  function automatic logic [47:0] tracking_offset();
    if ($urandom_range(0, 9) == 0) return random_offset();
    return offset_near_zero(24);
  endfunction

  task automatic send_item(input logic restart, input logic [47:0] off,
                           input logic [62:0] stamp);
    int unsigned gap;
    gap = pick_gap(sender_quiet);
    @(negedge clk);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_DATA_W'({stamp, off, restart});
    do @(posedge clk); while (!s_axis_tready);
    items_sent++;
  endtask

  // Registers change only once the servo has returned every result.
  task automatic quiesce();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    wait (pending == 0 && s_axis_tready);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [63:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= value[CFG_DATA_W-1:0];
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic program_servo(input int setting);
    logic [31:0]        kp, ki, wt;
    logic [29:0]        mf;
    logic [46:0]        st_thr, fs_thr;
    logic [35:0]        interval;
    logic signed [63:0] init_drift;
    kp         = $urandom >> $urandom_range(0, 8);
    ki         = $urandom >> $urandom_range(0, 8);
    wt         = $urandom >> $urandom_range(0, 6);
    mf         = 30'($urandom_range(0, 900000000));
    st_thr     = ($urandom_range(0, 2) == 0) ? 47'd0 :
                 47'({$urandom, $urandom}) & ((47'd1 << $urandom_range(1, 40)) - 47'd1);
    fs_thr     = 47'({$urandom, $urandom}) & ((47'd1 << $urandom_range(1, 40)) - 47'd1);
    interval   = 36'({$urandom, $urandom}) & ((36'd1 << $urandom_range(1, 30)) - 36'd1);
    init_drift = $signed({$urandom, $urandom}) >>> $urandom_range(17, 40);
    case (setting)
      0: begin
        kp         = $urandom_range(100000000, 300000000);
        ki         = $urandom_range(20000000, 120000000);
        wt         = 32'd268435456;
        mf         = 30'd500000;
        st_thr     = 47'd1000000;
        fs_thr     = 47'd20000;
        interval   = 36'd1000000;
        init_drift = $signed({$urandom, $urandom}) >>> 33;
      end
      1: begin
        kp         = '1;
        ki         = '1;
        wt         = '1;
        mf         = 30'd900000000;
        st_thr     = 47'h7FFF_FFFF_FFFF;
        fs_thr     = 47'h7FFF_FFFF_FFFF;
        interval   = 36'hF_FFFF_FFFF;
        init_drift = 64'sd58982400000000;
      end
      2: begin
        kp         = '0;
        ki         = '0;
        wt         = '0;
        mf         = '0;
        st_thr     = '0;
        fs_thr     = '0;
        interval   = '0;
        init_drift = -64'sd58982400000000;
      end
      3: begin
        // Clamp above the ceiling, and the most negative drift the field holds.
        mf         = 30'h3FFF_FFFF;
        st_thr     = 47'd1;
        fs_thr     = 47'd1;
        interval   = 36'd1;
        init_drift = -64'sd70368744177664;
      end
      4: init_drift = 64'sd70368744177663;
      default: ;
    endcase
    write_reg(REG_PROP_GAIN, kp);
    write_reg(REG_INT_GAIN, ki);
    write_reg(REG_WEIGHT, wt);
    write_reg(REG_MAX_FREQ, mf);
    write_reg(REG_STEP_THR, st_thr);
    write_reg(REG_FIRST_THR, fs_thr);
    write_reg(REG_EST_INT, interval);
    write_reg(REG_INIT_DRIFT, init_drift);
    est_gap = interval;
  endtask

  // Restart, then a sample past the estimate gap, then a run of tracking updates.
  task automatic lock_sequence();
    int unsigned n;
    n = $urandom_range(2, 10);
    now_ns += 63'($urandom_range(1, 1000));
    send_item(1'b1, offset_near_zero(20), now_ns);
    now_ns += 63'(est_gap) + 63'($urandom_range(1, 5000));
    send_item(1'b0, tracking_offset(), now_ns);
    repeat (n) begin
      now_ns += 63'($urandom_range(1, 2000000));
      send_item(1'b0, tracking_offset(), now_ns);
    end
    segment_items += n + 2;
  endtask

  task automatic noise_item();
    logic [63:0] raw;
    logic [62:0] stamp;
    raw = {$urandom, $urandom};
    case ($urandom_range(0, 4))
      0: stamp = now_ns - 63'($urandom_range(0, 1000));
      1: stamp = now_ns + 63'(est_gap >> 1);
      2: stamp = raw[62:0];
      default: begin
        now_ns += 63'($urandom_range(1, 100000000));
        stamp = now_ns;
      end
    endcase
    send_item($urandom_range(0, 3) == 0, random_offset(), stamp);
    segment_items++;
  endtask

  // Result side: random stalls, and one long hold-off so the servo backs up.
  initial begin
    int unsigned on_len, off_len;
    logic        held;
    held = 1'b0;
    @(negedge clk);
    forever begin
      if (!held && items_sent >= HOLD_AFTER) begin
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        held = 1'b1;
      end
      m_axis_tready <= 1'b1;
      on_len = $urandom_range(1, 200);
      repeat (on_len) @(negedge clk);
      off_len = ($urandom_range(0, 3) == 0) ? 0 : pick_gap(1'b0);
      if (off_len != 0) begin
        m_axis_tready <= 1'b0;
        repeat (off_len) @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        cfg_we) begin
      stall_cycles <= 0;
    end else if (stall_cycles == STALL_LIMIT) begin
      $display("pi_clock_servo regression: fail");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    repeat (3) @(negedge clk);
    rst <= 1'b0;

    // Register defaults: sample, equal time, short gap, first-step jump.
    send_item(1'b0, 48'd0, 63'd1000);
    send_item(1'b0, 48'd5, 63'd1000);
    send_item(1'b0, 48'd100, 63'd2000);
    send_item(1'b0, 48'd200, 63'd3000);
    send_item(1'b0, 48'd50000, 63'd53282053);
    // Tracking with the step threshold off, output pushed into both clamps.
    send_item(1'b0, 48'h7FFF_FFFF_FFFF, 63'd60000000);
    send_item(1'b0, 48'h8000_0000_0000, 63'd61000000);
    send_item(1'b0, 48'd0, 63'd62000000);
    send_item(1'b0, 48'hFFFF_FFFF_FFFF, 63'd63000000);
    send_item(1'b0, 48'd1, 63'd64000000);
    send_item(1'b0, -48'sd12345, 63'd65000000);
    // Restart at the top of the time range, then time wraps back to zero.
    send_item(1'b1, -48'sd100, 63'h7FFF_FFFF_FFFF_FFFF);
    send_item(1'b0, 48'd5, 63'd0);
    send_item(1'b1, 48'h8000_0000_0000, 63'd0);
    send_item(1'b0, 48'h7FFF_FFFF_FFFF, 63'h7FFF_FFFF_FFFF_FFFF);
    send_item(1'b0, 48'd777, 63'd1);
    send_item(1'b1, 48'h7FFF_FFFF_FFFF, 63'd0);
    send_item(1'b0, 48'h8000_0000_0000, 63'h7FFF_FFFF_FFFF_FFFF);
    send_item(1'b0, 48'd42, 63'd5);
    now_ns = 63'd1000;

    for (int seg = 0; seg < SEGMENTS; seg++) begin
      quiesce();
      program_servo(seg);
      segment_items = 0;
      while (segment_items < SEGMENT_ITEMS) begin
        sender_quiet = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 3) != 0) lock_sequence();
        else noise_item();
      end
    end

    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    wait (pending == 0);
    repeat (300) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("pi_clock_servo regression: pass");
    end else begin
      $display("pi_clock_servo regression: fail");
    end
    $finish;
  end

endmodule
